@@ rtl/rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Reference-counted slot pool package
// Shared types, codes and default sizes of the slot pool.
// ----------------------------------------------------------------------------
package rsp_pkg;

	localparam int OPC_W = 2;
	localparam int IDX_W = 8;
	localparam int ST_W = 2;
	localparam int CNT_OUT_W = 16;
	localparam int GEN_W = 64;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int GRP_SIZE = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_ACQUIRE = 2'd0,
		OP_ADDREF  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_INSPECT = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} st_t;

	typedef struct packed {
		logic accept;
		logic lookup;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

@@ rtl/rsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot pool controller
// Sequences each request through accept, lookup and execute.
// ----------------------------------------------------------------------------
module rsp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rsp_pkg::sts_t sts,
	output rsp_pkg::cmd_t cmd
);
	import rsp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_EXEC   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.lookup = (state_q == S_LOOKUP);
		cmd.commit = (state_q == S_EXEC) && sts.out_free;
		in_stall   = (state_q != S_IDLE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_LOOKUP)
		else $error("accepted request did not enter lookup");

	a_lookup_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOKUP |=> state_q == S_EXEC)
		else $error("lookup did not advance to execute");

	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && !sts.out_free |=> state_q == S_EXEC)
		else $error("execute left while output register was blocked");

endmodule

@@ rtl/rsp_datapath.sv @@
// ----------------------------------------------------------------------------
// Slot pool datapath
// Slot counters in memory, free-slot search, update logic and output register.
// ----------------------------------------------------------------------------
module rsp_datapath #(
	parameter int NUM_SLOTS = rsp_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_WIDTH = rsp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsp_pkg::cmd_t                 cmd,
	output rsp_pkg::sts_t                 sts,
	input  logic [rsp_pkg::OPC_W-1:0]     opcode,
	input  logic [rsp_pkg::IDX_W-1:0]     slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rsp_pkg::ST_W-1:0]      status,
	output logic [rsp_pkg::IDX_W-1:0]     slot_out,
	output logic [rsp_pkg::CNT_OUT_W-1:0] ref_count,
	output logic [rsp_pkg::GEN_W-1:0]     generation_out
);
	import rsp_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int NUM_GRP = (NUM_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int GRP_CNT = 1 << GRP_W;
	localparam int PAD_BITS = GRP_CNT * GRP_SIZE;
	localparam int OFF_W = $clog2(GRP_SIZE);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] cnt_mem [NUM_SLOTS];
	logic [GEN_W-1:0]       gen_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   valid_q;
	logic [NUM_SLOTS-1:0]   busy_q;

	logic [PAD_BITS-1:0] busy_pad;
	logic [GRP_CNT-1:0]  grp_full;
	logic [GRP_W-1:0]    free_grp;
	logic                any_free;

	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	logic [GRP_W-1:0] grp_s1;
	logic             any_free_s1;

	logic [GRP_SIZE-1:0] grp_bits;
	logic [OFF_W-1:0]    free_off;
	logic [IDX_W-1:0]    acq_slot;
	logic                in_range;
	logic [IDX_W-1:0]    look_slot;
	logic                look_hit;
	logic [SLOT_W-1:0]   look_addr;

	logic [IDX_W-1:0]       tgt_s2;
	logic                   hit_s2;
	logic                   rd_vld_s2;
	logic [COUNT_WIDTH-1:0] rd_cnt_s2;
	logic [GEN_W-1:0]       rd_gen_s2;

	logic [SLOT_W-1:0]      wr_addr;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [GEN_W-1:0]       cur_gen;
	logic [COUNT_WIDTH-1:0] new_cnt;
	logic [GEN_W-1:0]       new_gen;
	logic                   wr_en;
	st_t                    res_st;
	logic [IDX_W-1:0]       res_slot;
	logic [COUNT_WIDTH-1:0] res_cnt;
	logic [GEN_W-1:0]       res_gen;

	logic                   out_valid_q;
	st_t                    status_q;
	logic [IDX_W-1:0]       slot_q;
	logic [CNT_OUT_W-1:0]   cnt_q;
	logic [GEN_W-1:0]       gen_q;

	// Slots beyond the pool read as busy so the search never grants them.
	always_comb begin
		busy_pad = '1;
		busy_pad[NUM_SLOTS-1:0] = busy_q;
		for (int g = 0; g < GRP_CNT; g++) begin
			grp_full[g] = &busy_pad[g*GRP_SIZE +: GRP_SIZE];
		end
		free_grp = '0;
		for (int g = GRP_CNT - 1; g >= 0; g--) begin
			if (!grp_full[g]) begin
				free_grp = GRP_W'(g);
			end
		end
		any_free = ~&grp_full;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q        <= op_t'(opcode);
			idx_q       <= slot_index;
			grp_s1      <= free_grp;
			any_free_s1 <= any_free;
		end
	end

	always_comb begin
		grp_bits = busy_pad[grp_s1*GRP_SIZE +: GRP_SIZE];
		free_off = '0;
		for (int i = GRP_SIZE - 1; i >= 0; i--) begin
			if (!grp_bits[i]) begin
				free_off = OFF_W'(i);
			end
		end
		acq_slot  = IDX_W'({grp_s1, free_off});
		in_range  = {1'b0, idx_q} < (IDX_W + 1)'(NUM_SLOTS);
		look_slot = (op_q == OP_ACQUIRE) ? acq_slot : idx_q;
		look_hit  = (op_q == OP_ACQUIRE) ? any_free_s1 : in_range;
		look_addr = look_slot[SLOT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			tgt_s2    <= look_slot;
			hit_s2    <= look_hit;
			rd_vld_s2 <= valid_q[look_addr];
		end
	end

	assign wr_addr = tgt_s2[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			cnt_mem[wr_addr] <= new_cnt;
			gen_mem[wr_addr] <= new_gen;
		end
		if (cmd.lookup) begin
			rd_cnt_s2 <= cnt_mem[look_addr];
			rd_gen_s2 <= gen_mem[look_addr];
		end
	end

	always_comb begin
		cur_cnt  = rd_vld_s2 ? rd_cnt_s2 : '0;
		cur_gen  = rd_vld_s2 ? rd_gen_s2 : '0;
		new_cnt  = cur_cnt;
		new_gen  = cur_gen;
		wr_en    = 1'b0;
		res_st   = ST_OK;
		res_slot = tgt_s2;
		res_cnt  = '0;
		res_gen  = '0;
		if (!hit_s2) begin
			if (op_q == OP_ACQUIRE) begin
				res_st   = ST_FULL;
				res_slot = '0;
			end else begin
				res_st = ST_BAD;
			end
		end else begin
			case (op_q)
				OP_ACQUIRE: begin
					new_cnt = COUNT_WIDTH'(1);
					new_gen = cur_gen + GEN_W'(1);
					wr_en   = 1'b1;
				end
				OP_ADDREF: begin
					if ((cur_cnt == '0) || (cur_cnt == CNT_MAX)) begin
						res_st = ST_BAD;
					end else begin
						new_cnt = cur_cnt + COUNT_WIDTH'(1);
						wr_en   = 1'b1;
					end
				end
				OP_RELEASE: begin
					if (cur_cnt == '0) begin
						res_st = ST_BAD;
					end else begin
						new_cnt = cur_cnt - COUNT_WIDTH'(1);
						wr_en   = 1'b1;
					end
				end
				OP_INSPECT: begin
					res_st = ST_OK;
				end
				default: begin
					res_st = ST_BAD;
				end
			endcase
			res_cnt = new_cnt;
			res_gen = new_gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			busy_q  <= '0;
		end else if (cmd.commit && wr_en) begin
			valid_q[wr_addr] <= 1'b1;
			busy_q[wr_addr]  <= (new_cnt != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_st;
			slot_q   <= res_slot;
			cnt_q    <= CNT_OUT_W'(res_cnt);
			gen_q    <= res_gen;
		end
	end

	assign sts.out_free    = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign slot_out        = slot_q;
	assign ref_count       = cnt_q;
	assign generation_out  = gen_q;

	a_commit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result was not presented");

	a_acquire_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && hit_s2 && (op_q == OP_ACQUIRE) |-> cur_cnt == '0)
		else $error("acquire granted a slot that was in use");

	a_busy_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && wr_en |=>
		(busy_q[$past(wr_addr)] == ($past(new_cnt) != '0)) && valid_q[$past(wr_addr)])
		else $error("busy flag does not match the written count");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !hit_s2 && (op_q == OP_ACQUIRE) |=>
		(status_q == ST_FULL) && (slot_q == '0) && (cnt_q == '0) && (gen_q == '0))
		else $error("pool full result carries nonzero fields");

endmodule

@@ rtl/refcounted_slot_pool.sv @@
// ----------------------------------------------------------------------------
// Reference-counted slot pool
// Allocates slots and tracks a reference count and generation for each.
// ----------------------------------------------------------------------------
// Each request passes through these steps in turn: the cycle it
// is accepted in, a lookup cycle that picks the slot and reads its counters
// from memory, and an execute cycle that updates the counters and loads the
// output register. A stalled output register holds the execute cycle until it
// can take the result; a new request is accepted while a finished result is
// still waiting. The free-slot search for acquire is split over the accept and
// lookup cycles, first choosing a group of sixteen slots and then a slot in
// that group. Counters start at zero out of reset without any clearing pass,
// since a per-slot valid flag marks slots that were never written.
// ----------------------------------------------------------------------------
module refcounted_slot_pool #(
	parameter int NUM_SLOTS = rsp_pkg::NUM_SLOTS_DEF,
	parameter int COUNT_WIDTH = rsp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rsp_pkg::OPC_W-1:0]     opcode,
	input  logic [rsp_pkg::IDX_W-1:0]     slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rsp_pkg::ST_W-1:0]      status,
	output logic [rsp_pkg::IDX_W-1:0]     slot_out,
	output logic [rsp_pkg::CNT_OUT_W-1:0] ref_count,
	output logic [rsp_pkg::GEN_W-1:0]     generation_out
);
	import rsp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsp_datapath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.slot_index     (slot_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot_out       (slot_out),
		.ref_count      (ref_count),
		.generation_out (generation_out)
	);

endmodule

@@ tb/tb_refcounted_slot_pool.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the reference-counted slot pool
// Sends acquire, addref, release and inspect requests with random gaps and
// random output stalls. A scoreboard keeps its own copy of every slot's count
// and generation, predicts the result of each accepted request and checks the
// results in order.
// ----------------------------------------------------------------------------
module tb_refcounted_slot_pool;
	import rsp_pkg::*;

	localparam int POOL_SLOTS = NUM_SLOTS_DEF;
	localparam int CNT_W = COUNT_WIDTH_DEF;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int SETTLE_CYCLES = 20;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [ST_W-1:0]      status;
		logic [IDX_W-1:0]     slot;
		logic [CNT_OUT_W-1:0] cnt;
		logic [GEN_W-1:0]     gen;
	} pool_result_t;

	class pool_scoreboard;
		logic [CNT_W-1:0] counts [POOL_SLOTS];
		logic [GEN_W-1:0] gens [POOL_SLOTS];
		pool_result_t expected_results [$];
		int errors;

		function new();
			foreach (counts[i]) begin
				counts[i] = '0;
				gens[i] = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function int first_free();
			for (int i = 0; i < POOL_SLOTS; i++) begin
				if (counts[i] == '0)
					return i;
			end
			return -1;
		endfunction

		function void note_request(op_t op, logic [IDX_W-1:0] idx);
			pool_result_t r;
			int free_slot;
			r.status = ST_OK;
			r.slot = '0;
			r.cnt = '0;
			r.gen = '0;
			if (op == OP_ACQUIRE) begin
				free_slot = first_free();
				if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					counts[free_slot] = CNT_W'(1);
					gens[free_slot] = gens[free_slot] + GEN_W'(1);
					r.slot = IDX_W'(free_slot);
					r.cnt = CNT_OUT_W'(counts[free_slot]);
					r.gen = gens[free_slot];
				end
			end else if (idx >= POOL_SLOTS) begin
				r.status = ST_BAD;
				r.slot = idx;
			end else begin
				if (op == OP_ADDREF) begin
					if (counts[idx] == '0 || counts[idx] == COUNT_MAX)
						r.status = ST_BAD;
					else
						counts[idx] = counts[idx] + CNT_W'(1);
				end else if (op == OP_RELEASE) begin
					if (counts[idx] == '0)
						r.status = ST_BAD;
					else
						counts[idx] = counts[idx] - CNT_W'(1);
				end
				r.slot = idx;
				r.cnt = CNT_OUT_W'(counts[idx]);
				r.gen = gens[idx];
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [IDX_W-1:0] slot,
				logic [CNT_OUT_W-1:0] cnt, logic [GEN_W-1:0] gen);
			pool_result_t e;
			if (expected_results.size() == 0) begin
				$error("Result with no request outstanding: status %0d, slot %0d", st, slot);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (slot !== e.slot) begin
				$error("slot_out: expected %0d, got %0d", e.slot, slot);
				errors++;
			end
			if (cnt !== e.cnt) begin
				$error("ref_count: expected %0d, got %0d", e.cnt, cnt);
				errors++;
			end
			if (gen !== e.gen) begin
				$error("generation_out: expected %0d, got %0d", e.gen, gen);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OPC_W-1:0] opcode;
	logic [IDX_W-1:0] slot_index;
	logic out_valid;
	logic out_stall;
	logic [ST_W-1:0] status;
	logic [IDX_W-1:0] slot_out;
	logic [CNT_OUT_W-1:0] ref_count;
	logic [GEN_W-1:0] generation_out;

	pool_scoreboard sb;
	logic no_idle;
	int stall_left = 0;
	longint cycles = 0;

	refcounted_slot_pool u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot_out(slot_out),
		.ref_count(ref_count),
		.generation_out(generation_out)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int idle_len();
		if (no_idle || $urandom_range(0, 99) < 60)
			return 0;
		return gap_len();
	endfunction

	function automatic logic [IDX_W-1:0] pick_slot();
		if ($urandom_range(0, 99) < 15)
			return IDX_W'($urandom_range(0, 255));
		return IDX_W'($urandom_range(0, POOL_SLOTS - 1));
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return OP_ACQUIRE;
		if (r < 55)
			return OP_ADDREF;
		if (r < 85)
			return OP_RELEASE;
		return OP_INSPECT;
	endfunction

	// Called right after a rising edge; returns at the edge that accepts the request.
	task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		slot_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 99) < 25) begin
			stall_left <= gap_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(op_t'(opcode), slot_index);
			if (out_valid && !out_stall)
				sb.check_result(status, slot_out, ref_count, generation_out);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_ACQUIRE;
		slot_index = '0;
		out_stall = 1'b0;
		no_idle = 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh pool, then fill it, overfill it, free one slot again and try out-of-range slots.
		send_request(OP_INSPECT, 8'd0, idle_len());
		send_request(OP_RELEASE, 8'd0, idle_len());
		send_request(OP_ADDREF, 8'd0, idle_len());
		repeat (POOL_SLOTS) send_request(OP_ACQUIRE, 8'hFF, idle_len());
		send_request(OP_ACQUIRE, 8'd0, idle_len());
		send_request(OP_ADDREF, 8'd3, idle_len());
		send_request(OP_RELEASE, 8'd3, idle_len());
		send_request(OP_RELEASE, 8'd3, idle_len());
		send_request(OP_RELEASE, 8'd3, idle_len());
		send_request(OP_ACQUIRE, 8'd0, idle_len());
		send_request(OP_INSPECT, 8'd255, idle_len());
		send_request(OP_ADDREF, IDX_W'(POOL_SLOTS), idle_len());
		send_request(OP_RELEASE, 8'd170, idle_len());
		send_request(OP_INSPECT, 8'd85, idle_len());
		send_request(OP_INSPECT, IDX_W'(POOL_SLOTS - 1), idle_len());

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if ($urandom_range(0, 99) < 2)
				no_idle = ~no_idle;
			send_request(pick_op(), pick_slot(), idle_len());
		end
		no_idle = 1'b0;
		wait_drained();

		if (sb.pending() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
